// ===== hdl/min_cost_max_flow_unit_assert.svh =====
// Assertion macros for the min-cost max-flow unit.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef MIN_COST_MAX_FLOW_UNIT_ASSERT_SVH
`define MIN_COST_MAX_FLOW_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MCMF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MCMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mcmf_pkg.sv =====
// Package for the min-cost max-flow unit: sizes, codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcmf_pkg;

    localparam int NODE_W       = 7;
    localparam int NODE_DEPTH   = 128;
    localparam int MAX_ARCS_DEF = 2048;
    localparam int CAP_W        = 16;
    localparam int COST_W       = 16;
    localparam int RES_W        = 17;
    localparam int DIST_W       = 32;
    localparam int ENQ_W        = 8;
    localparam int FLOW_W       = 24;
    localparam int TCOST_W      = 32;
    localparam int NCOUNT_W     = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [RES_W-1:0]    BNECK_START  = '1;
    localparam logic [NODE_W-1:0]   SOURCE_RST   = 7'd1;
    localparam logic [NODE_W-1:0]   SINK_RST     = 7'd101;
    localparam logic [NCOUNT_W-1:0] NCOUNT_RST   = 8'd102;
    localparam logic [CAP_W-1:0]    REQUIRED_RST = 16'd2;

    typedef enum logic [1:0] {
        CFG_SOURCE   = 2'd0,
        CFG_SINK     = 2'd1,
        CFG_NODES    = 2'd2,
        CFG_REQUIRED = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LOW      = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/min_cost_max_flow_unit.sv =====
// Top level of the min-cost max-flow unit: arc loading, SPFA search and augmentation.
// Depends on mcmf_pkg, mcmf_ram and min_cost_max_flow_unit_assert.svh.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata arcs, tlast ends the job
// m_axis    out  tvalid/tready          tdata totals, tuser status
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An arc is stored in states LOAD0 to LOAD3 and LDONE, one entry at a time through
// the single write port of the arc memory. The last arc then runs searches: each
// sets up in INIT, pops in POP, scans arcs in ARC and augments in AUG and WALK.
// Reset needs no clearing pass; per-node valid bits mark empty adjacency lists.
// A finished result waits in the output register; new arcs are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "min_cost_max_flow_unit_assert.svh"

module min_cost_max_flow_unit #(
    parameter int MAX_ARCS = mcmf_pkg::MAX_ARCS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // arc_tail[6:0], arc_head[13:7], forward_capacity[29:14],
    // reverse_capacity[45:30], arc_cost[61:46], zero fill [63:62]
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // total_flow[23:0], total_cost[55:24]
    output logic [55:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NW    = mcmf_pkg::NODE_W;
    localparam int ND    = mcmf_pkg::NODE_DEPTH;
    localparam int AW    = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int NXW   = AW + 1;
    localparam int RW    = mcmf_pkg::RES_W;
    localparam int DW    = mcmf_pkg::DIST_W;
    localparam int EW    = mcmf_pkg::ENQ_W;
    localparam int CW    = mcmf_pkg::RES_W;
    localparam int ARC_W = NW + NW + CW + NXW;
    localparam int NODE_RAM_W = DW + AW + RW + EW;
    localparam int PW    = DW + RW + 1;
    localparam int SW    = PW + 1;
    localparam logic [NXW-1:0] NULL_ARC = {1'b1, {AW{1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD0, ST_LOAD1, ST_LOAD2, ST_LOAD3, ST_LDONE,
        ST_INIT, ST_POP, ST_POP2, ST_POP3, ST_ARC, ST_ARC2, ST_ARC3,
        ST_CHECK, ST_AUG, ST_AUG2, ST_WALK, ST_WALK2, ST_WALK3, ST_WALK4,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic [NW-1:0]              src_reg, snk_reg;
    logic [7:0]                 ncount_reg;
    logic [15:0]                req_reg;
    logic [AW:0]                arc_total_reg;
    logic                       overflow_reg;
    logic [23:0]                flow_acc_reg;
    logic signed [31:0]         cost_acc_reg;
    logic [ND-1:0]              first_vld_reg, reached_reg, inq_reg;
    logic [7:0]                 n_reg, qcount_reg, steps_reg;
    logic [NW-1:0]              qh_reg;
    logic [NXW-1:0]             k_reg;
    logic                       m_valid_reg;
    logic [23:0]                out_flow_reg;
    logic [31:0]                out_cost_reg;
    logic [1:0]                 out_status_reg;

    logic [NW-1:0]              tail_reg, head_reg, u_reg, v_reg;
    logic [15:0]                fcap_reg, rcap_reg, cost_reg;
    logic                       last_reg;
    logic signed [DW-1:0]       dist_u_reg, nd_reg;
    logic [RW-1:0]              bneck_u_reg, resid_reg, a_reg;
    logic [NXW-1:0]             next_reg;
    logic [AW-1:0]              karc_reg, wk_reg;
    logic signed [PW-1:0]       prod_reg;

    logic                       arc_we, res_we, first_we, node_we, q_we;
    logic [AW-1:0]              arc_waddr, arc_raddr, res_waddr, res_raddr;
    logic [ARC_W-1:0]           arc_wdata, arc_rdata;
    logic [RW-1:0]              res_wdata, res_rdata;
    logic [NW-1:0]              first_waddr, first_raddr, node_waddr, node_raddr;
    logic [NW-1:0]              q_waddr, q_raddr;
    logic [AW-1:0]              first_wdata, first_rdata;
    logic [NODE_RAM_W-1:0]      node_wdata, node_rdata;
    logic [NW-1:0]              q_wdata, q_rdata;

    logic [7:0]                 n_eff;
    logic                       path_ok;
    logic [CW-1:0]              cost_fwd, cost_rev;
    logic [AW-1:0]              arc_slot0, arc_slot1;
    logic [NXW-1:0]             nx_tail, nx_head;
    logic signed [DW-1:0]       nd_dist;
    logic [AW-1:0]              nd_pred;
    logic [RW-1:0]              nd_bneck;
    logic [EW-1:0]              nd_enq, enq_old, enq_new;
    logic [NW-1:0]              a_tail, a_head;
    logic [CW-1:0]              a_cost;
    logic [NXW-1:0]             a_next;
    logic                       better, stop;
    logic [RW-1:0]              bmin;
    logic [24:0]                flow_sum;
    logic signed [SW-1:0]       cost_sum;
    logic                       drop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_cost_reg, out_flow_reg};
    assign m_axis_tuser  = out_status_reg;

    assign n_eff    = (ncount_reg > 8'(ND)) ? 8'(ND) : ncount_reg;
    assign path_ok  = ({1'b0, src_reg} < n_eff) && ({1'b0, snk_reg} < n_eff)
                      && (src_reg != snk_reg);
    assign cost_fwd = {cost_reg[15], cost_reg};
    assign cost_rev = CW'(0 - {cost_reg[15], cost_reg});
    assign arc_slot0 = arc_total_reg[AW-1:0];
    assign arc_slot1 = AW'(arc_total_reg + 1'b1);
    assign nx_tail  = first_vld_reg[tail_reg] ? {1'b0, first_rdata} : NULL_ARC;
    assign nx_head  = first_vld_reg[head_reg] ? {1'b0, first_rdata} : NULL_ARC;
    assign drop     = (32'(arc_total_reg) + 32'd2) > 32'(MAX_ARCS);

    assign nd_dist  = node_rdata[DW-1:0];
    assign nd_pred  = node_rdata[DW +: AW];
    assign nd_bneck = node_rdata[DW+AW +: RW];
    assign nd_enq   = node_rdata[DW+AW+RW +: EW];
    assign a_tail   = arc_rdata[0 +: NW];
    assign a_head   = arc_rdata[NW +: NW];
    assign a_cost   = arc_rdata[2*NW +: CW];
    assign a_next   = arc_rdata[2*NW+CW +: NXW];

    assign better   = !reached_reg[v_reg] || (nd_dist > nd_reg);
    assign enq_old  = reached_reg[v_reg] ? nd_enq : '0;
    assign enq_new  = inq_reg[v_reg] ? enq_old : EW'(enq_old + 1'b1);
    assign stop     = better && !inq_reg[v_reg] && (enq_old >= n_reg);
    assign bmin     = (bneck_u_reg < resid_reg) ? bneck_u_reg : resid_reg;
    assign flow_sum = {1'b0, flow_acc_reg} + 25'(a_reg);
    assign cost_sum = SW'(cost_acc_reg) + SW'(prod_reg);

    always_comb
    begin
        arc_we = 1'b0; arc_waddr = arc_slot0; arc_wdata = '0; arc_raddr = k_reg[AW-1:0];
        res_we = 1'b0; res_waddr = arc_slot0; res_wdata = '0; res_raddr = k_reg[AW-1:0];
        first_we = 1'b0; first_waddr = tail_reg; first_wdata = arc_slot0;
        first_raddr = tail_reg;
        node_we = 1'b0; node_waddr = v_reg; node_wdata = '0; node_raddr = v_reg;
        q_we = 1'b0; q_waddr = NW'(qh_reg + qcount_reg[NW-1:0]); q_wdata = v_reg;
        q_raddr = qh_reg;
        unique case (state_reg)
            ST_LOAD1:
            begin
                arc_we    = 1'b1;
                arc_wdata = {nx_tail, cost_fwd, head_reg, tail_reg};
                res_we    = 1'b1;
                res_wdata = RW'(fcap_reg);
                first_we  = 1'b1;
            end
            ST_LOAD2:
            begin
                first_raddr = head_reg;
            end
            ST_LOAD3:
            begin
                arc_we      = 1'b1;
                arc_waddr   = arc_slot1;
                arc_wdata   = {nx_head, cost_rev, tail_reg, head_reg};
                res_we      = 1'b1;
                res_waddr   = arc_slot1;
                res_wdata   = RW'(rcap_reg);
                first_we    = 1'b1;
                first_waddr = head_reg;
                first_wdata = arc_slot1;
            end
            ST_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = src_reg;
                node_wdata = {EW'(1), mcmf_pkg::BNECK_START, {AW{1'b0}}, {DW{1'b0}}};
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = src_reg;
            end
            ST_POP2:
            begin
                node_raddr  = q_rdata;
                first_raddr = q_rdata;
            end
            ST_ARC2:
            begin
                node_raddr = a_head;
            end
            ST_ARC3:
            begin
                node_we    = better && !stop;
                node_wdata = {enq_new, bmin, karc_reg, nd_reg};
                q_we       = better && !stop && !inq_reg[v_reg];
            end
            ST_CHECK:
            begin
                node_raddr = snk_reg;
            end
            ST_WALK:
            begin
                node_raddr = u_reg;
            end
            ST_WALK2:
            begin
                arc_raddr = nd_pred;
                res_raddr = nd_pred;
            end
            ST_WALK3:
            begin
                res_we    = 1'b1;
                res_waddr = wk_reg;
                res_wdata = RW'(res_rdata - a_reg);
                res_raddr = {wk_reg[AW-1:1], ~wk_reg[0]};
            end
            ST_WALK4:
            begin
                res_we    = 1'b1;
                res_waddr = {wk_reg[AW-1:1], ~wk_reg[0]};
                res_wdata = RW'(res_rdata + a_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            src_reg        <= mcmf_pkg::SOURCE_RST;
            snk_reg        <= mcmf_pkg::SINK_RST;
            ncount_reg     <= mcmf_pkg::NCOUNT_RST;
            req_reg        <= mcmf_pkg::REQUIRED_RST;
            arc_total_reg  <= '0;
            overflow_reg   <= 1'b0;
            flow_acc_reg   <= '0;
            cost_acc_reg   <= '0;
            first_vld_reg  <= '0;
            reached_reg    <= '0;
            inq_reg        <= '0;
            n_reg          <= '0;
            qcount_reg     <= '0;
            steps_reg      <= '0;
            qh_reg         <= '0;
            k_reg          <= NULL_ARC;
            m_valid_reg    <= 1'b0;
            out_flow_reg   <= '0;
            out_cost_reg   <= '0;
            out_status_reg <= mcmf_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (mcmf_pkg::cfg_index_t'(cfg_index))
                    mcmf_pkg::CFG_SOURCE:   src_reg    <= cfg_data[NW-1:0];
                    mcmf_pkg::CFG_SINK:     snk_reg    <= cfg_data[NW-1:0];
                    mcmf_pkg::CFG_NODES:    ncount_reg <= cfg_data[7:0];
                    mcmf_pkg::CFG_REQUIRED: req_reg    <= cfg_data;
                endcase
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_LOAD0;
                    end
                end
                ST_LOAD0:
                begin
                    if (drop)
                    begin
                        overflow_reg <= 1'b1;
                        state_reg    <= ST_LDONE;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD1;
                    end
                end
                ST_LOAD1:
                begin
                    first_vld_reg[tail_reg] <= 1'b1;
                    state_reg <= ST_LOAD2;
                end
                ST_LOAD2:
                begin
                    state_reg <= ST_LOAD3;
                end
                ST_LOAD3:
                begin
                    first_vld_reg[head_reg] <= 1'b1;
                    arc_total_reg <= (AW+1)'(arc_total_reg + 2'd2);
                    state_reg     <= ST_LDONE;
                end
                ST_LDONE:
                begin
                    state_reg <= last_reg ? ST_INIT : ST_IDLE;
                end
                ST_INIT:
                begin
                    n_reg <= n_eff;
                    if (path_ok)
                    begin
                        reached_reg          <= '0;
                        reached_reg[src_reg] <= 1'b1;
                        inq_reg              <= '0;
                        inq_reg[src_reg]     <= 1'b1;
                        qh_reg               <= '0;
                        qcount_reg           <= 8'd1;
                        state_reg            <= ST_POP;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_POP:
                begin
                    if (qcount_reg == '0)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        qh_reg     <= NW'(qh_reg + 1'b1);
                        qcount_reg <= 8'(qcount_reg - 1'b1);
                        state_reg  <= ST_POP2;
                    end
                end
                ST_POP2:
                begin
                    inq_reg[q_rdata] <= 1'b0;
                    state_reg <= ST_POP3;
                end
                ST_POP3:
                begin
                    k_reg     <= first_vld_reg[u_reg] ? {1'b0, first_rdata} : NULL_ARC;
                    state_reg <= ST_ARC;
                end
                ST_ARC:
                begin
                    state_reg <= k_reg[AW] ? ST_POP : ST_ARC2;
                end
                ST_ARC2:
                begin
                    if (({1'b0, a_head} >= n_reg) || (res_rdata == '0))
                    begin
                        k_reg     <= a_next;
                        state_reg <= ST_ARC;
                    end
                    else
                    begin
                        state_reg <= ST_ARC3;
                    end
                end
                ST_ARC3:
                begin
                    k_reg <= next_reg;
                    if (stop)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_ARC;
                        if (better)
                        begin
                            reached_reg[v_reg] <= 1'b1;
                            if (!inq_reg[v_reg])
                            begin
                                inq_reg[v_reg] <= 1'b1;
                                qcount_reg     <= 8'(qcount_reg + 1'b1);
                            end
                        end
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= reached_reg[snk_reg] ? ST_AUG : ST_FINISH;
                end
                ST_AUG:
                begin
                    state_reg <= ST_AUG2;
                end
                ST_AUG2:
                begin
                    flow_acc_reg <= flow_sum[24] ? '1 : flow_sum[23:0];
                    if (cost_sum > SW'(33'sh0_7FFF_FFFF))
                    begin
                        cost_acc_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (cost_sum < -SW'(33'sh0_8000_0000))
                    begin
                        cost_acc_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        cost_acc_reg <= cost_sum[31:0];
                    end
                    steps_reg <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    state_reg <= ((u_reg == src_reg) || (steps_reg >= n_reg)) ? ST_INIT
                                                                              : ST_WALK2;
                end
                ST_WALK2:
                begin
                    state_reg <= ({1'b0, nd_pred} >= arc_total_reg) ? ST_INIT : ST_WALK3;
                end
                ST_WALK3:
                begin
                    state_reg <= ST_WALK4;
                end
                ST_WALK4:
                begin
                    steps_reg <= 8'(steps_reg + 1'b1);
                    state_reg <= ST_WALK;
                end
                ST_FINISH:
                begin
                    if (!m_valid_reg)
                    begin
                        m_valid_reg  <= 1'b1;
                        out_flow_reg <= flow_acc_reg;
                        out_cost_reg <= cost_acc_reg;
                        if (overflow_reg)
                        begin
                            out_status_reg <= mcmf_pkg::STATUS_OVERFLOW;
                        end
                        else if (flow_acc_reg < 24'(req_reg))
                        begin
                            out_status_reg <= mcmf_pkg::STATUS_LOW;
                        end
                        else
                        begin
                            out_status_reg <= mcmf_pkg::STATUS_OK;
                        end
                        first_vld_reg <= '0;
                        arc_total_reg <= '0;
                        overflow_reg  <= 1'b0;
                        flow_acc_reg  <= '0;
                        cost_acc_reg  <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                tail_reg <= s_axis_tdata[6:0];
                head_reg <= s_axis_tdata[13:7];
                fcap_reg <= s_axis_tdata[29:14];
                rcap_reg <= s_axis_tdata[45:30];
                cost_reg <= s_axis_tdata[61:46];
                last_reg <= s_axis_tlast;
            end
            ST_POP2:
            begin
                u_reg <= q_rdata;
            end
            ST_POP3:
            begin
                dist_u_reg  <= nd_dist;
                bneck_u_reg <= nd_bneck;
            end
            ST_ARC:
            begin
                karc_reg <= k_reg[AW-1:0];
            end
            ST_ARC2:
            begin
                v_reg     <= a_head;
                resid_reg <= res_rdata;
                nd_reg    <= dist_u_reg + DW'($signed(a_cost));
                next_reg  <= a_next;
            end
            ST_AUG:
            begin
                a_reg    <= nd_bneck;
                prod_reg <= nd_dist * $signed({1'b0, nd_bneck});
                u_reg    <= snk_reg;
            end
            ST_WALK2:
            begin
                wk_reg <= nd_pred;
            end
            ST_WALK3:
            begin
                u_reg <= a_tail;
            end
            default:
            begin
            end
        endcase
    end

    mcmf_ram #(.WIDTH(ARC_W), .DEPTH(MAX_ARCS)) u_arc_ram (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
        .raddr(arc_raddr), .rdata(arc_rdata)
    );

    mcmf_ram #(.WIDTH(RW), .DEPTH(MAX_ARCS)) u_res_ram (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata)
    );

    mcmf_ram #(.WIDTH(AW), .DEPTH(ND)) u_first_ram (
        .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
        .raddr(first_raddr), .rdata(first_rdata)
    );

    mcmf_ram #(.WIDTH(NODE_RAM_W), .DEPTH(ND)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    mcmf_ram #(.WIDTH(NW), .DEPTH(ND)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    `MCMF_ASSERT_ALWAYS(a_queue_bound, qcount_reg <= n_reg, "work queue holds more than n nodes")
    `MCMF_ASSERT_ALWAYS(a_arc_pairs, arc_total_reg[0] == 1'b0, "arc count is odd")
    `MCMF_ASSERT_NEXT(a_finish_clear, (state_reg == ST_FINISH) && !m_valid_reg, (arc_total_reg == '0) && m_valid_reg && (state_reg == ST_IDLE), "job end did not clear graph")

endmodule

`default_nettype wire

// ===== hdl/mcmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== verif/min_cost_max_flow_unit_tb.sv =====
// Self-checking testbench for min_cost_max_flow_unit: arc jobs are streamed in, totals and status checked.
// Depends on mcmf_pkg and the RTL of min_cost_max_flow_unit; holds its own flow predictor.
`timescale 1ns / 1ps

module min_cost_max_flow_unit_tb;
    import mcmf_pkg::*;

    localparam int ARC_LIMIT  = 2048;
    localparam int NODE_LIMIT = 128;
    localparam int CYCLE_CAP  = 6000000;

    typedef struct {
        logic [6:0]  tail;
        logic [6:0]  head;
        logic [15:0] fcap;
        logic [15:0] rcap;
        logic [15:0] cost;
        logic        last;
    } arc_item_t;

    typedef struct {
        logic [23:0] flow;
        logic [31:0] cost;
        status_t     status;
    } flow_total_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    min_cost_max_flow_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    arc_item_t   arc_queue[$];
    flow_total_t totals_due[$];
    arc_item_t   cur_arc;
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          taken = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          hold_left = 0;

    // Predictor state.
    int unsigned src_node = SOURCE_RST, snk_node = SINK_RST;
    int unsigned node_total = NCOUNT_RST, need_flow = REQUIRED_RST;
    int          g_tail[ARC_LIMIT], g_head[ARC_LIMIT], g_cap[ARC_LIMIT];
    int          g_flow[ARC_LIMIT], g_cost[ARC_LIMIT], g_next[ARC_LIMIT];
    int          g_first[NODE_LIMIT];
    int          g_arcs;
    longint      d_dist[NODE_LIMIT];
    bit          d_seen[NODE_LIMIT], d_inq[NODE_LIMIT];
    int          d_enq[NODE_LIMIT], d_pred[NODE_LIMIT], d_bneck[NODE_LIMIT];
    int          d_fifo[NODE_LIMIT];
    int unsigned flow_sum;
    longint      cost_sum;
    bit          table_full;

    function automatic void clear_graph();
        for (int i = 0; i < NODE_LIMIT; i++) g_first[i] = -1;
        g_arcs = 0;
        flow_sum = 0;
        cost_sum = 0;
        table_full = 1'b0;
    endfunction

    function automatic void add_arc(int from, int to, int cap, int cost);
        int k;
        k = g_arcs;
        g_tail[k] = from;
        g_head[k] = to;
        g_cap[k] = cap;
        g_flow[k] = 0;
        g_cost[k] = cost;
        g_next[k] = g_first[from];
        g_first[from] = k;
        g_arcs = k + 1;
    endfunction

    // 0: no path, 1: augmented, 2: stopped by the negative cycle guard.
    function automatic int augment_once(int n, int s, int t);
        int qh, qn, u, v, k, resid, a, steps;
        longint nd, sum;
        qh = 0;
        for (int i = 0; i < n; i++)
        begin
            d_seen[i] = 0;
            d_inq[i] = 0;
            d_enq[i] = 0;
        end
        d_dist[s] = 0;
        d_seen[s] = 1;
        d_inq[s] = 1;
        d_enq[s] = 1;
        d_pred[s] = -1;
        d_bneck[s] = 32'h3f3f3f3f;
        d_fifo[0] = s;
        qn = 1;
        while (qn > 0)
        begin
            u = d_fifo[qh];
            qh = (qh + 1) % NODE_LIMIT;
            qn--;
            d_inq[u] = 0;
            for (k = g_first[u]; k >= 0; k = g_next[k])
            begin
                v = g_head[k];
                resid = g_cap[k] - g_flow[k];
                nd = d_dist[u] + longint'(g_cost[k]);
                if (v >= n || resid <= 0) continue;
                if (!d_seen[v] || d_dist[v] > nd)
                begin
                    d_dist[v] = nd;
                    d_seen[v] = 1;
                    d_pred[v] = k;
                    d_bneck[v] = d_bneck[u] < resid ? d_bneck[u] : resid;
                    if (!d_inq[v])
                    begin
                        if (d_enq[v] >= n) return 2;
                        d_enq[v]++;
                        d_fifo[(qh + qn) % NODE_LIMIT] = v;
                        qn++;
                        d_inq[v] = 1;
                    end
                end
            end
        end
        if (!d_seen[t]) return 0;
        a = d_bneck[t];
        flow_sum = flow_sum + a;
        if (flow_sum > 24'hffffff) flow_sum = 24'hffffff;
        sum = cost_sum + d_dist[t] * longint'(a);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        cost_sum = sum;
        u = t;
        for (steps = 0; u != s && steps < n; steps++)
        begin
            k = d_pred[u];
            if (k < 0 || k >= g_arcs) break;
            g_flow[k] += a;
            g_flow[k ^ 1] -= a;
            u = g_tail[k];
        end
        return 1;
    endfunction

    function automatic void predict_arc(arc_item_t it);
        int n;
        flow_total_t r;
        if (g_arcs + 2 > ARC_LIMIT)
            table_full = 1'b1;
        else
        begin
            add_arc(it.tail, it.head, it.fcap, int'($signed(it.cost)));
            add_arc(it.head, it.tail, it.rcap, -int'($signed(it.cost)));
        end
        if (!it.last) return;
        n = node_total < NODE_LIMIT ? node_total : NODE_LIMIT;
        if (src_node < n && snk_node < n && src_node != snk_node)
            while (augment_once(n, src_node, snk_node) == 1) ;
        r.flow = flow_sum[23:0];
        r.cost = cost_sum[31:0];
        if (table_full) r.status = STATUS_OVERFLOW;
        else if (flow_sum < need_flow) r.status = STATUS_LOW;
        else r.status = STATUS_OK;
        totals_due.push_back(r);
        clear_graph();
    endfunction

    initial clear_graph();

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("min_cost_max_flow_unit regression: fail");
            $finish;
        end
    end

    // Arc driver.
    always @(posedge clk)
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_arc(cur_arc);
            taken <= 1'b1;
        end

    always @(negedge clk)
    begin
        taken <= 1'b0;
        if (!s_axis_tvalid || taken)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                src_gap = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end
            else if (arc_queue.size() > 0)
            begin
                cur_arc = arc_queue.pop_front();
                s_axis_tdata <= {2'b00, cur_arc.cost, cur_arc.rcap, cur_arc.fcap,
                                 cur_arc.head, cur_arc.tail};
                s_axis_tlast <= cur_arc.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else if (snk_gap > 0)
        begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            snk_gap = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (totals_due.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                flow_total_t e;
                e = totals_due.pop_front();
                if (m_axis_tdata[23:0] !== e.flow)
                begin
                    $error("total_flow expected %0d actual %0d", e.flow, m_axis_tdata[23:0]);
                    errors++;
                end
                if (m_axis_tdata[55:24] !== e.cost)
                begin
                    $error("total_cost expected %0d actual %0d", $signed(e.cost),
                           $signed(m_axis_tdata[55:24]));
                    errors++;
                end
                if (m_axis_tuser !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_axis_tuser);
                    errors++;
                end
            end
        end

    task automatic push_arc(int t, int h, int fc, int rc, int c, bit l);
        arc_item_t it;
        it.tail = t;
        it.head = h;
        it.fcap = fc;
        it.rcap = rc;
        it.cost = c;
        it.last = l;
        arc_queue.push_back(it);
    endtask

    task automatic wait_idle();
        while (arc_queue.size() > 0 || s_axis_tvalid || totals_due.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_SOURCE:   src_node = val & 8'h7f;
            CFG_SINK:     snk_node = val & 8'h7f;
            CFG_NODES:    node_total = val & 8'hff;
            CFG_REQUIRED: need_flow = val & 16'hffff;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int s, int t, int n, int req);
        wait_idle();
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_SINK, t);
        write_reg(CFG_NODES, n);
        write_reg(CFG_REQUIRED, req);
    endtask

    function automatic int pick_node(int n);
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic random_job(int n, int s, int t);
        int cnt, a, b, fc, rc, c;
        cnt = $urandom_range(1, 12);
        for (int i = 0; i < cnt; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                a = s;
                b = pick_node(n);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                a = pick_node(n);
                b = t;
            end
            else
            begin
                a = pick_node(n);
                b = pick_node(n);
            end
            fc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 20);
            rc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 0;
            c = $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 60);
            push_arc(a, b, fc, rc, c, i == cnt - 1);
        end
    endtask

    initial
    begin
        int n, s, t, sent;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a graph with three paths, one of them over a reverse arc, and the most negative cost.
        push_arc(1, 5, 3, 0, 10, 0);
        push_arc(5, 101, 2, 0, 1, 0);
        push_arc(1, 101, 4, 0, 50, 0);
        push_arc(7, 1, 0, 9, 16'h8000, 0);
        push_arc(7, 101, 9, 0, 0, 0);
        push_arc(127, 120, 65535, 65535, 16'h7fff, 1);

        // Low node count: arcs into nodes above it are never used.
        set_all(0, 1, 2, 65535);
        push_arc(0, 1, 65535, 0, 16'h7fff, 0);
        push_arc(0, 2, 5, 0, 0, 0);
        push_arc(2, 1, 5, 0, 0, 1);
        // Cost saturates high, then low.
        push_arc(0, 1, 65535, 0, 16'h7fff, 0);
        push_arc(0, 1, 65535, 0, 16'h7fff, 1);
        push_arc(0, 1, 65535, 0, 16'h8000, 0);
        push_arc(0, 1, 65535, 0, 16'h8000, 1);

        // Source equal to sink, then source out of range.
        set_all(3, 3, 128, 0);
        push_arc(3, 4, 7, 0, 1, 1);
        set_all(127, 0, 1, 1);
        push_arc(127, 0, 7, 0, 1, 1);

        // Negative cycle reachable from the source.
        set_all(0, 3, 4, 1);
        push_arc(0, 1, 5, 0, 1, 0);
        push_arc(1, 2, 5, 0, 16'hfffb, 0);
        push_arc(2, 1, 5, 0, 16'hfffb, 0);
        push_arc(2, 3, 5, 0, 1, 1);

        // Arc table overflow, with one usable arc among unreachable ones.
        set_all(0, 1, 8, 0);
        push_arc(0, 1, 9, 0, 3, 0);
        for (int i = 0; i < 1024; i++) push_arc(5, 6, 1, 0, 1, i == 1023);

        // Flow saturates at 24 bits over many parallel arcs.
        set_all(0, 1, 2, 0);
        for (int i = 0; i < 257; i++) push_arc(0, 1, 65535, 0, 0, i == 256);

        // Random phases; the receiver holds off once while jobs pile up.
        sent = 0;
        while (sent < 1800)
        begin
            case ($urandom_range(0, 5))
                0: n = 1;
                1: n = 128;
                2: n = 2;
                default: n = $urandom_range(2, 16);
            endcase
            s = pick_node(n);
            t = $urandom_range(0, 7) == 0 ? s : pick_node(n);
            set_all(s, t, n,
                    $urandom_range(0, 3) == 0 ? 65535 * $urandom_range(0, 1)
                                              : $urandom_range(0, 40));
            if (sent > 1600) calm = 1'b1;
            if (sent == 0) hold_left = 3000;
            for (int j = $urandom_range(4, 10); j > 0; j--) random_job(n, s, t);
            sent += arc_queue.size();
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("min_cost_max_flow_unit regression: pass");
        else
            $display("min_cost_max_flow_unit regression: fail");
        $finish;
    end
endmodule

// ===== min_cost_max_flow_unit.f =====
+incdir+hdl
hdl/mcmf_pkg.sv
hdl/mcmf_ram.sv
hdl/min_cost_max_flow_unit.sv
verif/min_cost_max_flow_unit_tb.sv
